[hw/rtl/alu8u_pkg.sv]
// alu8u_pkg: shared types, opcode constants and constant tables for the 8-bit alu
// no dependencies; imported by every stage module and the top level
package alu8u_pkg;

  // alu modes as carried on alu_mode
  typedef enum logic [2:0] {
    MODE_ADD     = 3'd0,
    MODE_ADD_INC = 3'd1,
    MODE_SUB     = 3'd2,
    MODE_SUB_DEC = 3'd3,
    MODE_AND     = 3'd4,
    MODE_INC     = 3'd5,
    MODE_DEC     = 3'd6,
    MODE_UNARY   = 3'd7
  } mode_t;

  // unary sub-op groups, taken from operand_b[7:3]
  localparam logic [4:0] GRP_SETFLAGS = 5'd0;
  localparam logic [4:0] GRP_SETBIT   = 5'd1;
  localparam logic [4:0] GRP_CLRBIT   = 5'd2;
  localparam logic [4:0] GRP_GETBIT   = 5'd3;
  localparam logic [4:0] GRP_MULLO    = 5'd4;
  localparam logic [4:0] GRP_MULHI    = 5'd5;
  localparam logic [4:0] GRP_DIV      = 5'd6;
  localparam logic [4:0] GRP_MOD      = 5'd7;
  localparam logic [4:0] GRP_LSL      = 5'd8;
  localparam logic [4:0] GRP_LSR      = 5'd9;
  localparam logic [4:0] GRP_MISC     = 5'd10;

  // single unary codes inside the misc group
  localparam logic [7:0] CODE_SWAP    = 8'd80;
  localparam logic [7:0] CODE_REVERSE = 8'd81;
  localparam logic [7:0] CODE_NEGATE  = 8'd82;
  localparam logic [7:0] CODE_INVERT  = 8'd83;

  // what the later stages still have to do with a word
  typedef enum logic [2:0] {
    OP_PLAIN,
    OP_MULLO,
    OP_MULHI,
    OP_DIV,
    OP_MOD,
    OP_SETFLAGS,
    OP_UNUSED
  } op_t;

  // status flag bit positions
  localparam int FLAG_Z = 0;
  localparam int FLAG_C = 1;
  localparam int FLAG_V = 2;

  // multiplier and reciprocal widths
  localparam int FACT_W      = 7;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = 8 + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  // constant factor selected by the low three bits of the sub-op code
  function automatic logic [FACT_W-1:0] factor(input logic [2:0] n);
    logic [FACT_W-1:0] k;
    unique case (n)
      3'd0: k = 7'd3;
      3'd1: k = 7'd5;
      3'd2: k = 7'd10;
      3'd3: k = 7'd15;
      3'd4: k = 7'd50;
      3'd5: k = 7'd60;
      3'd6: k = 7'd80;
      3'd7: k = 7'd100;
    endcase
    return k;
  endfunction

  // floor(2^16 / k) + 1: exact quotient for any 8-bit dividend
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      3'd0: m = 15'd21846;
      3'd1: m = 15'd13108;
      3'd2: m = 15'd6554;
      3'd3: m = 15'd4370;
      3'd4: m = 15'd1311;
      3'd5: m = 15'd1093;
      3'd6: m = 15'd820;
      3'd7: m = 15'd656;
    endcase
    return m;
  endfunction

  // word leaving the multiply stage
  typedef struct packed {
    logic [7:0]        a;
    logic [7:0]        b;
    mode_t             mode;
    op_t               op;
    logic [PROD_W-1:0] prod;
  } s1_t;

  // word leaving the execute stage
  typedef struct packed {
    logic [7:0] a;
    op_t        op;
    logic [7:0] res;
    logic [2:0] flags;
    logic [7:0] qk;
  } s2_t;

endpackage

[hw/rtl/alu8u_mul_stage.sv]
// alu8u_mul_stage: first stage, sub-op decode and the shared constant multiplier
// depends on alu8u_pkg
module alu8u_mul_stage import alu8u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [2:0] alu_mode,
  output logic       s1_valid,
  output s1_t        s1,
  input  logic       down_ready
);

  mode_t             mode;
  op_t               op;
  logic [RECIP_W-1:0] mop;
  s1_t               s1_next;

  assign mode = mode_t'(alu_mode);

  // decode what the later stages need to know
  always_comb begin
    if (mode != MODE_UNARY) begin
      op = OP_PLAIN;
    end else begin
      priority case (operand_b[7:3])
        GRP_SETFLAGS: op = OP_SETFLAGS;
        GRP_MULLO:    op = OP_MULLO;
        GRP_MULHI:    op = OP_MULHI;
        GRP_DIV:      op = OP_DIV;
        GRP_MOD:      op = OP_MOD;
        GRP_SETBIT, GRP_CLRBIT, GRP_GETBIT, GRP_LSL, GRP_LSR: op = OP_PLAIN;
        default: begin
          if (operand_b >= CODE_SWAP && operand_b <= CODE_INVERT) op = OP_PLAIN;
          else op = OP_UNUSED;
        end
      endcase
    end
  end

  // one multiplier: by the factor, or by its reciprocal for div and mod
  always_comb begin
    if (op == OP_DIV || op == OP_MOD) mop = recip(operand_b[2:0]);
    else mop = {{(RECIP_W-FACT_W){1'b0}}, factor(operand_b[2:0])};
    s1_next.a    = operand_a;
    s1_next.b    = operand_b;
    s1_next.mode = mode;
    s1_next.op   = op;
    s1_next.prod = PROD_W'(operand_a) * PROD_W'(mop);
  end

  // stage handshake
  assign in_ready = !s1_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (in_ready) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1 <= s1_next;
  end

endmodule

[hw/rtl/alu8u_exec_stage.sv]
// alu8u_exec_stage: second stage, arithmetic, logic, shifts and quotient pickup
// depends on alu8u_pkg
module alu8u_exec_stage import alu8u_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s1_valid,
  input  s1_t  s1,
  output logic s1_ready,
  output logic s2_valid,
  output s2_t  s2,
  input  logic down_ready
);

  logic [2:0]        n;
  logic [QUOT_W-1:0] quot;
  logic [FACT_W-1:0] k;
  logic [13:0]       qk_full;
  logic [8:0]        sum9;
  logic [8:0]        wide9;
  logic [7:0]        res;
  logic [7:0]        rev;
  logic [2:0]        flags;
  s2_t               s2_next;

  assign n       = s1.b[2:0];
  assign quot    = s1.prod[PROD_W-1:RECIP_SHIFT];
  assign k       = factor(n);
  assign qk_full = {{(14-QUOT_W){1'b0}}, quot} * {{(14-FACT_W){1'b0}}, k};

  // bit reverse
  always_comb begin
    for (int i = 0; i < 8; i++) rev[i] = s1.a[7-i];
  end

  // result and carry per mode
  always_comb begin
    res   = 8'h00;
    flags = 3'b000;
    sum9  = 9'd0;
    wide9 = 9'd0;
    unique case (s1.mode)
      MODE_ADD: begin
        sum9 = {1'b0, s1.a} + {1'b0, s1.b};
        res  = sum9[7:0];
        flags[FLAG_C] = sum9[8];
      end
      MODE_ADD_INC: begin
        sum9 = {1'b0, s1.a} + {1'b0, s1.b} + 9'd1;
        res  = sum9[7:0];
        flags[FLAG_C] = sum9[8];
      end
      MODE_SUB: begin
        res = s1.a - s1.b;
        flags[FLAG_C] = s1.a < s1.b;
      end
      MODE_SUB_DEC: begin
        res = s1.a - s1.b - 8'd1;
        flags[FLAG_C] = s1.a <= s1.b;
      end
      MODE_AND: res = s1.a & s1.b;
      MODE_INC: begin
        res = s1.a + 8'd1;
        flags[FLAG_C] = s1.a == 8'hff;
      end
      MODE_DEC: begin
        res = s1.a - 8'd1;
        flags[FLAG_C] = s1.a == 8'h00;
      end
      MODE_UNARY: begin
        priority case (s1.b[7:3])
          GRP_SETFLAGS: begin
            res   = s1.b;
            flags = s1.b[2:0];
          end
          GRP_SETBIT: res = s1.a | (8'd1 << n);
          GRP_CLRBIT: res = s1.a & ~(8'd1 << n);
          GRP_GETBIT: res = {7'd0, s1.a[n]};
          GRP_MULLO:  res = s1.prod[7:0];
          GRP_MULHI:  res = s1.prod[15:8];
          GRP_DIV:    res = 8'(quot);
          GRP_MOD:    res = 8'h00;
          GRP_LSL: begin
            wide9 = {1'b0, s1.a} << n;
            res   = wide9[7:0];
            flags[FLAG_C] = wide9[8];
          end
          GRP_LSR: begin
            wide9 = {s1.a, 1'b0} >> n;
            res   = wide9[8:1];
            flags[FLAG_C] = wide9[0];
          end
          default: begin
            priority case (s1.b)
              CODE_SWAP:    res = {s1.a[3:0], s1.a[7:4]};
              CODE_REVERSE: res = rev;
              CODE_NEGATE:  res = 8'd0 - s1.a;
              CODE_INVERT:  res = ~s1.a;
              default: begin
                res   = 8'hff;
                flags = 3'b111;
              end
            endcase
          end
        endcase
      end
    endcase
    s2_next.a     = s1.a;
    s2_next.op    = s1.op;
    s2_next.res   = res;
    s2_next.flags = flags;
    s2_next.qk    = qk_full[7:0];
  end

  // stage handshake
  assign s1_ready = !s2_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (s1_ready) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) s2 <= s2_next;
  end

endmodule

[hw/rtl/alu8u_flag_stage.sv]
// alu8u_flag_stage: last stage, remainder fix-up, zero and sign-change flags
// depends on alu8u_pkg; drives the output register
module alu8u_flag_stage import alu8u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s2_valid,
  input  s2_t        s2,
  output logic       s2_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] alu_result,
  output logic [2:0] status_flags
);

  logic [7:0] res;
  logic [2:0] flags;

  // remainder and automatic flags
  always_comb begin
    res   = (s2.op == OP_MOD) ? s2.a - s2.qk : s2.res;
    flags = s2.flags;
    if (s2.op != OP_SETFLAGS && s2.op != OP_UNUSED) begin
      flags[FLAG_Z] = res == 8'h00;
      flags[FLAG_V] = res[7] != s2.a[7];
    end
  end

  // output register handshake
  assign s2_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (s2_ready) out_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      alu_result   <= res;
      status_flags <= flags;
    end
  end

endmodule

[hw/rtl/eight_bit_alu_with_unary_ops.sv]
// eight_bit_alu_with_unary_ops: top level of the three-stage 8-bit alu
// depends on alu8u_pkg, alu8u_mul_stage, alu8u_exec_stage, alu8u_flag_stage
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   input    | in_valid / in_stall  | operand_a, operand_b, alu_mode
//   output   | out_valid / out_stall| alu_result, status_flags
//
// one word per cycle while out_stall is low; a word passes s1, s2 and the output
// register in order. the depth is set by the constant multiplier, the remainder
// product and the flag logic each owning a stage. rst (synchronous) empties all
// stages. a stall holds the output register and, through the combinational
// ready chain, every full stage behind it; bubbles fill before in_stall rises.
module eight_bit_alu_with_unary_ops import alu8u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [2:0] alu_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] alu_result,
  output logic [2:0] status_flags
);

  logic in_ready;
  logic s1_valid;
  logic s1_ready;
  logic s2_valid;
  logic s2_ready;
  s1_t  s1;
  s2_t  s2;

  assign in_stall = !in_ready;

  // decode and multiply
  alu8u_mul_stage u_mul (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .alu_mode   (alu_mode),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .down_ready (s1_ready)
  );

  // execute
  alu8u_exec_stage u_exec (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s1_ready   (s1_ready),
    .s2_valid   (s2_valid),
    .s2         (s2),
    .down_ready (s2_ready)
  );

  // flags and output register
  alu8u_flag_stage u_flag (
    .clk          (clk),
    .rst          (rst),
    .s2_valid     (s2_valid),
    .s2           (s2),
    .s2_ready     (s2_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alu_result   (alu_result),
    .status_flags (status_flags)
  );

endmodule

[hw/rtl/alu8u_checker.sv]
// alu8u_checker: port-level assertions for the 8-bit alu, bound to the top level
// depends on eight_bit_alu_with_unary_ops port names only
module alu8u_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] operand_a,
  input logic [7:0] operand_b,
  input logic [2:0] alu_mode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] alu_result,
  input logic [2:0] status_flags
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alu_result) && $stable(status_flags))
    else $error("stalled output word changed");

  // input backs up only behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // an accepted word reaches out_valid through an unstalled pipe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |-> ##1 out_valid)
    else $error("word lost or late in pipeline");

  // zero flag agrees with the result except for loaded flags and unused codes
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_flags[0] |->
      alu_result == 8'h00 || alu_result == {5'd0, status_flags} || alu_result == 8'hff)
    else $error("zero flag set on nonzero result");

endmodule

bind eight_bit_alu_with_unary_ops alu8u_checker u_alu8u_checker (.*);

[tb/sv/tb_eight_bit_alu_with_unary_ops.sv]
// tb_eight_bit_alu_with_unary_ops: self-checking bench for the 8-bit alu with unary ops
// depends on alu8u_pkg and eight_bit_alu_with_unary_ops; predicts every word and
// checks each output word in order under random input gaps and output stalls
module tb_eight_bit_alu_with_unary_ops import alu8u_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // one operation word going in
  typedef struct {
    logic [7:0] a;
    logic [7:0] b;
    mode_t      mode;
  } alu_word_t;

  // predicted result word
  typedef struct {
    logic [7:0] res;
    logic [2:0] flags;
  } alu_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] operand_a = 8'd0;
  logic [7:0] operand_b = 8'd0;
  logic [2:0] alu_mode = 3'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] alu_result;
  logic [2:0] status_flags;

  logic       in_taken = 1'b0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         n_queued = 0;
  int         n_accepted = 0;
  int         n_checked = 0;
  int         n_errors = 0;
  int         n_phases = 0;

  alu_word_t  pending_words[$];
  alu_res_t   expected_results[$];

  eight_bit_alu_with_unary_ops u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .alu_mode     (alu_mode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alu_result   (alu_result),
    .status_flags (status_flags)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predict result and flags of one operation word
  function automatic alu_res_t alu_predict(logic [7:0] a, logic [7:0] b, mode_t mode);
    alu_res_t   o;
    logic [8:0] sum;
    logic [15:0] prod;
    logic [7:0] k;
    logic [2:0] n;
    logic       auto_flags;
    int         i;
    n = b[2:0];
    o.res = 8'd0;
    o.flags = 3'd0;
    auto_flags = 1'b1;
    case (n)
      3'd0: k = 8'd3;
      3'd1: k = 8'd5;
      3'd2: k = 8'd10;
      3'd3: k = 8'd15;
      3'd4: k = 8'd50;
      3'd5: k = 8'd60;
      3'd6: k = 8'd80;
      default: k = 8'd100;
    endcase
    prod = {8'd0, a} * {8'd0, k};
    case (mode)
      MODE_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        o.res = sum[7:0];
        o.flags[FLAG_C] = sum[8];
      end
      MODE_ADD_INC: begin
        sum = {1'b0, a} + {1'b0, b} + 9'd1;
        o.res = sum[7:0];
        o.flags[FLAG_C] = sum[8];
      end
      MODE_SUB: begin
        o.res = a - b;
        o.flags[FLAG_C] = (a < b);
      end
      MODE_SUB_DEC: begin
        o.res = a - b - 8'd1;
        o.flags[FLAG_C] = (a <= b);
      end
      MODE_AND: o.res = a & b;
      MODE_INC: begin
        o.res = a + 8'd1;
        o.flags[FLAG_C] = (a == 8'hff);
      end
      MODE_DEC: begin
        o.res = a - 8'd1;
        o.flags[FLAG_C] = (a == 8'h00);
      end
      default: begin
        // unary group, sub-op chosen by operand b
        case (b[7:3])
          GRP_SETFLAGS: begin
            o.res = b;
            o.flags = b[2:0];
            auto_flags = 1'b0;
          end
          GRP_SETBIT: o.res = a | (8'd1 << n);
          GRP_CLRBIT: o.res = a & ~(8'd1 << n);
          GRP_GETBIT: o.res = {7'd0, a[n]};
          GRP_MULLO:  o.res = prod[7:0];
          GRP_MULHI:  o.res = prod[15:8];
          GRP_DIV:    o.res = a / k;
          GRP_MOD:    o.res = a % k;
          GRP_LSL: begin
            o.res = a << n;
            if (n != 3'd0) o.flags[FLAG_C] = a[8 - n];
          end
          GRP_LSR: begin
            o.res = a >> n;
            if (n != 3'd0) o.flags[FLAG_C] = a[n - 1];
          end
          default: begin
            case (b)
              CODE_SWAP:   o.res = {a[3:0], a[7:4]};
              CODE_REVERSE: begin
                for (i = 0; i < 8; i++) o.res[7 - i] = a[i];
              end
              CODE_NEGATE: o.res = 8'd0 - a;
              CODE_INVERT: o.res = ~a;
              default: begin
                // unused code: all ones, all flags
                o.res = 8'hff;
                o.flags = 3'b111;
                auto_flags = 1'b0;
              end
            endcase
          end
        endcase
      end
    endcase
    if (auto_flags) begin
      o.flags[FLAG_V] = o.res[7] ^ a[7];
      o.flags[FLAG_Z] = (o.res == 8'd0);
    end
    return o;
  endfunction

  task automatic add_word(logic [7:0] a, logic [7:0] b, mode_t mode);
    alu_word_t w;
    w.a = a;
    w.b = b;
    w.mode = mode;
    pending_words.push_back(w);
    n_queued++;
  endtask

  // random operand, biased toward the edges now and then
  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return ($urandom_range(0, 1) != 0) ? 8'h7f : 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random_words(int count);
    int         i;
    mode_t      mode;
    logic [7:0] b;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) mode = MODE_UNARY;
      else mode = mode_t'($urandom_range(0, 7));
      if (mode == MODE_UNARY) begin
        if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(84, 255));
        else b = 8'($urandom_range(0, 83));
      end else begin
        b = rand_operand();
      end
      add_word(rand_operand(), b, mode);
    end
  endtask

  // wait until every queued word went in and every result came out
  task automatic wait_drained();
    @(negedge clk);
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin
    alu_word_t w;
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          w = pending_words.pop_front();
          in_valid  <= 1'b1;
          operand_a <= w.a;
          operand_b <= w.b;
          alu_mode  <= w.mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk) begin
    alu_res_t e;
    in_taken <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(alu_predict(operand_a, operand_b, mode_t'(alu_mode)));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected output word result=%h flags=%b", $realtime,
                   alu_result, status_flags);
          n_errors++;
        end else begin
          e = expected_results.pop_front();
          if (alu_result !== e.res) begin
            $display("%0t: alu_result mismatch on word %0d: expected %h, actual %h",
                     $realtime, n_checked, e.res, alu_result);
            n_errors++;
          end
          if (status_flags !== e.flags) begin
            $display("%0t: status_flags mismatch on word %0d: expected %b, actual %b",
                     $realtime, n_checked, e.flags, status_flags);
            n_errors++;
          end
          n_checked++;
        end
      end
    end
  end

  // stimulus phases
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, no idling
    add_word(8'hff, 8'h01, MODE_ADD);
    add_word(8'hff, 8'h00, MODE_ADD_INC);
    add_word(8'h00, 8'h01, MODE_SUB);
    add_word(8'h05, 8'h05, MODE_SUB_DEC);
    add_word(8'hf0, 8'h0f, MODE_AND);
    add_word(8'hff, 8'h00, MODE_INC);
    add_word(8'h00, 8'hff, MODE_DEC);
    add_word(8'hff, {GRP_SETFLAGS, 3'd7}, MODE_UNARY);
    add_word(8'h00, {GRP_SETBIT, 3'd7}, MODE_UNARY);
    add_word(8'hff, {GRP_CLRBIT, 3'd7}, MODE_UNARY);
    add_word(8'h08, {GRP_GETBIT, 3'd3}, MODE_UNARY);
    add_word(8'hff, {GRP_MULLO, 3'd7}, MODE_UNARY);
    add_word(8'hff, {GRP_MULHI, 3'd7}, MODE_UNARY);
    add_word(8'hff, {GRP_DIV, 3'd0}, MODE_UNARY);
    add_word(8'hff, {GRP_MOD, 3'd7}, MODE_UNARY);
    add_word(8'h80, {GRP_LSL, 3'd0}, MODE_UNARY);
    add_word(8'hff, {GRP_LSL, 3'd7}, MODE_UNARY);
    add_word(8'h01, {GRP_LSR, 3'd0}, MODE_UNARY);
    add_word(8'h80, {GRP_LSR, 3'd7}, MODE_UNARY);
    add_word(8'ha5, CODE_SWAP, MODE_UNARY);
    add_word(8'h01, CODE_REVERSE, MODE_UNARY);
    add_word(8'h80, CODE_NEGATE, MODE_UNARY);
    add_word(8'h00, CODE_INVERT, MODE_UNARY);
    add_word(8'h12, CODE_INVERT + 8'd1, MODE_UNARY);
    add_word(8'h00, 8'hff, MODE_UNARY);
    n_phases++;
    wait_drained();

    // random phases; sender holds off between them until the pipe is empty
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
        3: begin src_idle_pct = 17; sink_stall_pct = 17; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      add_random_words(390);
      n_phases++;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d words in %0d phases (all modes and unary codes, mixed gaps/stalls)",
             n_accepted, n_phases);
    $display("%0d output words checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("eight_bit_alu_with_unary_ops test passed");
    end else begin
      $display("eight_bit_alu_with_unary_ops test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("eight_bit_alu_with_unary_ops test failed");
    $finish;
  end

endmodule
